>>> hw/rtl/swsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swsu_pkg
// Shared types and constants of the map search and update unit.
// ----------------------------------------------------------------------------
package swsu_pkg;

    // configuration register indexes (byte address / 4)
    localparam logic [2:0] REG_MAP_SIDE   = 3'd0;
    localparam logic [2:0] REG_VEC_LEN    = 3'd1;
    localparam logic [2:0] REG_RADIUS     = 3'd2;
    localparam logic [2:0] REG_LEARN_RATE = 3'd3;
    localparam logic [2:0] REG_LEARN_EN   = 3'd4;

    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_PRESENT = 1'b1;

    localparam int DIST_W = 37;
    localparam int BEST_RESET_W = 38;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_SCAN = 2'd1,
        OP_EMIT = 2'd2,
        OP_UPD  = 2'd3
    } t_op;

    typedef struct packed {
        logic wr_w;      // weight word write from the request
        logic ld_x;      // load one input component
        logic ld_last;   // final component, clear the component count
        t_op  op;        // datapath pass for the issued read
        logic clr_best;  // restart the minimum search
        logic first;     // first component of a unit
        logic last;      // last component of a unit
    } t_dp_cmd;

endpackage
`default_nettype wire

>>> hw/rtl/swsu_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swsu_ctrl
// Sequencer: map scan, winner readout and neighbourhood update passes.
// ----------------------------------------------------------------------------
module swsu_ctrl import swsu_pkg::*; #(
    parameter int MAP_SIDE_MAX = 16,
    parameter int VECTOR_MAX   = 32,
    localparam int RW = $clog2(MAP_SIDE_MAX),
    localparam int KW = (VECTOR_MAX > 1) ? $clog2(VECTOR_MAX) : 1,
    localparam int AW = $clog2(MAP_SIDE_MAX * MAP_SIDE_MAX * VECTOR_MAX)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_action,
    input  wire logic          i_last,
    input  wire logic [4:0]    i_map_side,
    input  wire logic [5:0]    i_vector_length,
    input  wire logic [3:0]    i_radius,
    input  wire logic          i_learn_enable,
    input  wire logic [RW-1:0] i_best_row,
    input  wire logic [RW-1:0] i_best_col,
    output logic               o_busy,
    output t_dp_cmd            o_cmd,
    output logic [RW-1:0]      o_row,
    output logic [RW-1:0]      o_col,
    output logic [KW-1:0]      o_k,
    output logic [AW-1:0]      o_rd_addr
);

    localparam int SW = $clog2(MAP_SIDE_MAX + 1);
    localparam int LW = $clog2(VECTOR_MAX + 1);
    localparam int BW = ((RW > 4) ? RW : 4) + 2;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_EMIT  = 6'b001000,
        ST_UPD   = 6'b010000,
        ST_FLUSH = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [RW-1:0] r_row, n_row, r_col, n_col;
    logic [KW-1:0] r_k, n_k;
    logic [RW-1:0] r_r1, n_r1, r_c0, n_c0, r_c1, n_c1;
    logic          r_wait, n_wait;

    logic [SW-1:0] side;
    logic [LW-1:0] len;
    logic          accept, k_end, col_end, row_end;
    logic [RW-1:0] row_max;
    logic [BW-1:0] b_br, b_bc, b_rad, b_smax, b_t;
    logic [RW-1:0] lo_r, lo_c, hi_r, hi_c;

    always_comb begin
        if (i_map_side == 5'd0) begin
            side = SW'(1);
        end else if (int'(i_map_side) > MAP_SIDE_MAX) begin
            side = SW'(MAP_SIDE_MAX);
        end else begin
            side = SW'(i_map_side);
        end
        if (i_vector_length == 6'd0) begin
            len = LW'(1);
        end else if (int'(i_vector_length) > VECTOR_MAX) begin
            len = LW'(VECTOR_MAX);
        end else begin
            len = LW'(i_vector_length);
        end
    end

    assign row_max = RW'(side - SW'(1));
    assign k_end   = (r_k == KW'(len - LW'(1)));

    // clipped neighbourhood around the winner
    always_comb begin
        b_br   = BW'(i_best_row);
        b_bc   = BW'(i_best_col);
        b_rad  = BW'(i_radius);
        b_smax = BW'(row_max);
        lo_r   = (b_br >= b_rad) ? RW'(b_br - b_rad) : '0;
        lo_c   = (b_bc >= b_rad) ? RW'(b_bc - b_rad) : '0;
        b_t    = b_br + b_rad;
        hi_r   = (b_t > b_smax) ? row_max : RW'(b_t);
        b_t    = b_bc + b_rad;
        hi_c   = (b_t > b_smax) ? row_max : RW'(b_t);
    end

    assign accept = i_start && !o_busy;
    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        col_end = (r_state == ST_UPD) ? (r_col == r_c1) : (r_col == row_max);
        row_end = (r_state == ST_UPD) ? (r_row == r_r1) : (r_row == row_max);
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_k     = r_k;
        n_r1    = r_r1;
        n_c0    = r_c0;
        n_c1    = r_c1;
        n_wait  = r_wait;
        o_cmd   = '0;
        o_cmd.op = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.wr_w = (i_action == ACT_WRITE);
                    o_cmd.ld_x = (i_action == ACT_PRESENT);
                    if (i_action == ACT_PRESENT && i_last) begin
                        o_cmd.ld_last = 1'b1;
                        n_state = ST_SCAN;
                        n_row   = '0;
                        n_col   = '0;
                        n_k     = '0;
                    end
                end
            end
            ST_SCAN, ST_UPD: begin
                o_cmd.op       = (r_state == ST_SCAN) ? OP_SCAN : OP_UPD;
                o_cmd.clr_best = (r_state == ST_SCAN) && (r_row == '0)
                                 && (r_col == '0) && (r_k == '0);
                o_cmd.first    = (r_k == '0);
                o_cmd.last     = k_end;
                if (!k_end) begin
                    n_k = r_k + KW'(1);
                end else begin
                    n_k = '0;
                    if (!col_end) begin
                        n_col = r_col + RW'(1);
                    end else begin
                        n_col = (r_state == ST_UPD) ? r_c0 : '0;
                        if (!row_end) begin
                            n_row = r_row + RW'(1);
                        end else begin
                            n_state = (r_state == ST_SCAN) ? ST_DRAIN : ST_FLUSH;
                            n_wait  = 1'b0;
                        end
                    end
                end
            end
            ST_DRAIN, ST_FLUSH: begin
                // let the last pass leave the pipeline
                n_wait = 1'b1;
                if (r_wait) begin
                    n_state = (r_state == ST_DRAIN) ? ST_EMIT : ST_IDLE;
                    n_k     = '0;
                end
            end
            ST_EMIT: begin
                o_cmd.op    = OP_EMIT;
                o_cmd.first = (r_k == '0);
                o_cmd.last  = k_end;
                if (!k_end) begin
                    n_k = r_k + KW'(1);
                end else begin
                    n_k = '0;
                    if (i_learn_enable) begin
                        n_state = ST_UPD;
                        n_row   = lo_r;
                        n_col   = lo_c;
                        n_r1    = hi_r;
                        n_c0    = lo_c;
                        n_c1    = hi_c;
                    end else begin
                        n_state = ST_FLUSH;
                        n_wait  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (r_state == ST_EMIT) begin
            o_row = i_best_row;
            o_col = i_best_col;
        end else begin
            o_row = r_row;
            o_col = r_col;
        end
        o_k = r_k;
        o_rd_addr = AW'((int'(o_row) * MAP_SIDE_MAX + int'(o_col)) * VECTOR_MAX + int'(r_k));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
            r_wait  <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r1 <= n_r1;
        r_c0 <= n_c0;
        r_c1 <= n_c1;
    end

`ifndef SYNTHESIS
    a_last_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == ACT_PRESENT && i_last) |=> (r_state == ST_SCAN))
        else $error("last component did not start a scan");

    a_emit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && $past(r_state) != ST_EMIT) |-> $past(r_state) == ST_DRAIN)
        else $error("readout entered without draining the scan");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_EMIT || r_state == ST_UPD)
        |-> (LW'(r_k) < len))
        else $error("component counter beyond vector length");

    a_upd_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> (r_row <= r_r1 && r_col >= r_c0 && r_col <= r_c1))
        else $error("update left the neighbourhood");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/swsu_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swsu_dp
// Datapath: weight memory, input buffer, distance accumulator, minimum
// tracking, readout register and weight update pipe.
// ----------------------------------------------------------------------------
module swsu_dp import swsu_pkg::*; #(
    parameter int MAP_SIDE_MAX = 16,
    parameter int VECTOR_MAX   = 32,
    parameter int WEIGHT_BITS  = 16,
    localparam int RW = $clog2(MAP_SIDE_MAX),
    localparam int KW = (VECTOR_MAX > 1) ? $clog2(VECTOR_MAX) : 1,
    localparam int AW = $clog2(MAP_SIDE_MAX * MAP_SIDE_MAX * VECTOR_MAX)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_dp_cmd       i_cmd,
    input  wire logic [RW-1:0] i_row,
    input  wire logic [RW-1:0] i_col,
    input  wire logic [KW-1:0] i_k,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic [3:0]    i_unit_row,
    input  wire logic [3:0]    i_unit_col,
    input  wire logic [4:0]    i_component,
    input  wire logic [15:0]   i_value,
    input  wire logic [15:0]   i_learn_rate,
    output logic [RW-1:0]      o_best_row,
    output logic [RW-1:0]      o_best_col,
    output logic               o_strobe,
    output logic [3:0]         o_winner_row,
    output logic [3:0]         o_winner_col,
    output logic [36:0]        o_best_distance,
    output logic [15:0]        o_weight_out,
    output logic               o_end_of_run
);

    localparam int DEPTH  = MAP_SIDE_MAX * MAP_SIDE_MAX * VECTOR_MAX;
    localparam int LW     = $clog2(VECTOR_MAX + 1);
    localparam int SQ_W   = 2 * WEIGHT_BITS;
    localparam int ACC_W  = SQ_W + LW;
    localparam int BEST_W = (ACC_W > BEST_RESET_W) ? ACC_W : BEST_RESET_W;
    localparam int PR_W   = WEIGHT_BITS + 18;

    logic [WEIGHT_BITS-1:0] r_mem [DEPTH];
    logic [WEIGHT_BITS-1:0] r_ibuf [VECTOR_MAX];
    logic [LW-1:0]          r_cnt;

    logic [WEIGHT_BITS-1:0] r_w, r_x, r_s2_w;
    t_op                    r_s1_op, r_s2_op;
    logic                   r_s1_first, r_s1_last, r_s2_first, r_s2_last;
    logic [RW-1:0]          r_s1_row, r_s1_col, r_s2_row, r_s2_col;
    logic [AW-1:0]          r_s1_addr, r_s2_addr;
    logic [SQ_W-1:0]        r_sq;
    logic signed [PR_W-1:0] r_prod;
    logic [ACC_W-1:0]       r_acc, n_acc;
    logic [BEST_W-1:0]      r_best;

    logic                        ext_we, upd_we;
    logic [AW-1:0]               ext_addr;
    logic signed [WEIGHT_BITS:0] diff;
    logic signed [WEIGHT_BITS+1:0] step, n_w_ext;
    logic [WEIGHT_BITS-1:0]      n_upd_w;

    assign ext_we = i_cmd.wr_w && (int'(i_unit_row) < MAP_SIDE_MAX)
                    && (int'(i_unit_col) < MAP_SIDE_MAX)
                    && (int'(i_component) < VECTOR_MAX);
    assign ext_addr = AW'((int'(i_unit_row) * MAP_SIDE_MAX + int'(i_unit_col)) * VECTOR_MAX
                          + int'(i_component));
    assign upd_we = (r_s2_op == OP_UPD);

    // floor(rate * (x - w) / 2^16) is an arithmetic shift of the product
    assign diff    = $signed({1'b0, r_x}) - $signed({1'b0, r_w});
    assign step    = r_prod[PR_W-1:16];
    assign n_w_ext = $signed({2'b00, r_s2_w}) + step;
    assign n_upd_w = n_w_ext[WEIGHT_BITS-1:0];
    assign n_acc   = r_s2_first ? ACC_W'(r_sq) : r_acc + ACC_W'(r_sq);

    always_ff @(posedge i_clk) begin
        if (ext_we) begin
            r_mem[ext_addr] <= WEIGHT_BITS'(i_value);
        end else if (upd_we) begin
            r_mem[r_s2_addr] <= n_upd_w;
        end
        r_w <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_x && r_cnt < LW'(VECTOR_MAX)) begin
            r_ibuf[r_cnt[KW-1:0]] <= WEIGHT_BITS'(i_value);
        end
        r_x <= r_ibuf[i_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.ld_last) begin
            r_cnt <= '0;
        end else if (i_cmd.ld_x && r_cnt < LW'(VECTOR_MAX)) begin
            r_cnt <= r_cnt + LW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_op  <= OP_NONE;
            r_s2_op  <= OP_NONE;
            o_strobe <= 1'b0;
        end else begin
            r_s1_op  <= i_cmd.op;
            r_s2_op  <= r_s1_op;
            o_strobe <= (r_s1_op == OP_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.first;
        r_s1_last  <= i_cmd.last;
        r_s1_row   <= i_row;
        r_s1_col   <= i_col;
        r_s1_addr  <= i_rd_addr;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_row   <= r_s1_row;
        r_s2_col   <= r_s1_col;
        r_s2_addr  <= r_s1_addr;
        r_s2_w     <= r_w;
        r_sq       <= SQ_W'(diff * diff);
        r_prod     <= PR_W'(diff * $signed({1'b0, i_learn_rate}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best     <= '1;
            o_best_row <= '0;
            o_best_col <= '0;
        end else if (i_cmd.clr_best) begin
            r_best     <= '1;
            o_best_row <= '0;
            o_best_col <= '0;
        end else if (r_s2_op == OP_SCAN && r_s2_last && BEST_W'(n_acc) < r_best) begin
            r_best     <= BEST_W'(n_acc);
            o_best_row <= r_s2_row;
            o_best_col <= r_s2_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_op == OP_SCAN) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_op == OP_EMIT) begin
            o_winner_row    <= 4'(o_best_row);
            o_winner_col    <= 4'(o_best_col);
            o_best_distance <= (r_best > BEST_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(r_best);
            o_weight_out    <= 16'(r_w);
            o_end_of_run    <= r_s1_last;
        end
    end

`ifndef SYNTHESIS
    a_strobe_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_s1_op) == OP_EMIT)
        else $error("result strobe without readout pass");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.wr_w && upd_we))
        else $error("request write during weight update");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LW'(VECTOR_MAX))
        else $error("component count beyond buffer");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/som_winner_search_and_update_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// som_winner_search_and_update_unit
// Square self-organizing map: best matching unit search and neighbourhood
// training, with an APB register port.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-------------------------------
//  request  | i_start & !o_busy              | action, row, col, component,
//           |                                | value, last
//  result   | o_strobe, one cycle, no stall  | winner row/col, distance,
//           |                                | weight word, end_of_run
//  config   | psel & penable & pwrite        | paddr, pwdata (prdata read)
//
// A weight write or a non-last component is accepted while idle. A last component
// runs the scan of side*side*len words (one memory read per cycle), then
// the readout of len words, then (learning on) the update of each word in the
// clipped neighbourhood, with a drain state after the scan and a flush state
// at the end; o_busy is high throughout.
// Reset is synchronous; the weight memory is not cleared.
// ----------------------------------------------------------------------------
module som_winner_search_and_update_unit import swsu_pkg::*; #(
    parameter int MAP_SIDE_MAX = 16,
    parameter int VECTOR_MAX   = 32,
    parameter int WEIGHT_BITS  = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_action,
    input  wire logic [3:0]  i_unit_row,
    input  wire logic [3:0]  i_unit_col,
    input  wire logic [4:0]  i_component,
    input  wire logic [15:0] i_value,
    input  wire logic        i_last,
    output logic             o_strobe,
    output logic [3:0]       o_winner_row,
    output logic [3:0]       o_winner_col,
    output logic [36:0]      o_best_distance,
    output logic [15:0]      o_weight_out,
    output logic             o_end_of_run,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int RW = $clog2(MAP_SIDE_MAX);
    localparam int KW = (VECTOR_MAX > 1) ? $clog2(VECTOR_MAX) : 1;
    localparam int AW = $clog2(MAP_SIDE_MAX * MAP_SIDE_MAX * VECTOR_MAX);

    logic [4:0]  r_map_side;
    logic [5:0]  r_vector_length;
    logic [3:0]  r_radius;
    logic [15:0] r_learn_rate;
    logic        r_learn_enable;

    t_dp_cmd       cmd;
    logic [RW-1:0] row, col, best_row, best_col;
    logic [KW-1:0] k;
    logic [AW-1:0] rd_addr;
    logic          cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_side      <= 5'd16;
            r_vector_length <= 6'd32;
            r_radius        <= 4'd1;
            r_learn_rate    <= 16'd6554;
            r_learn_enable  <= 1'b1;
        end else if (cfg_we) begin
            case (paddr[4:2])
                REG_MAP_SIDE:   r_map_side      <= pwdata[4:0];
                REG_VEC_LEN:    r_vector_length <= pwdata[5:0];
                REG_RADIUS:     r_radius        <= pwdata[3:0];
                REG_LEARN_RATE: r_learn_rate    <= pwdata[15:0];
                REG_LEARN_EN:   r_learn_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_MAP_SIDE:   prdata = {27'd0, r_map_side};
            REG_VEC_LEN:    prdata = {26'd0, r_vector_length};
            REG_RADIUS:     prdata = {28'd0, r_radius};
            REG_LEARN_RATE: prdata = {16'd0, r_learn_rate};
            REG_LEARN_EN:   prdata = {31'd0, r_learn_enable};
            default:        prdata = '0;
        endcase
    end

    swsu_ctrl #(
        .MAP_SIDE_MAX (MAP_SIDE_MAX),
        .VECTOR_MAX   (VECTOR_MAX)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_action        (i_action),
        .i_last          (i_last),
        .i_map_side      (r_map_side),
        .i_vector_length (r_vector_length),
        .i_radius        (r_radius),
        .i_learn_enable  (r_learn_enable),
        .i_best_row      (best_row),
        .i_best_col      (best_col),
        .o_busy          (o_busy),
        .o_cmd           (cmd),
        .o_row           (row),
        .o_col           (col),
        .o_k             (k),
        .o_rd_addr       (rd_addr)
    );

    swsu_dp #(
        .MAP_SIDE_MAX (MAP_SIDE_MAX),
        .VECTOR_MAX   (VECTOR_MAX),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_row           (row),
        .i_col           (col),
        .i_k             (k),
        .i_rd_addr       (rd_addr),
        .i_unit_row      (i_unit_row),
        .i_unit_col      (i_unit_col),
        .i_component     (i_component),
        .i_value         (i_value),
        .i_learn_rate    (r_learn_rate),
        .o_best_row      (best_row),
        .o_best_col      (best_col),
        .o_strobe        (o_strobe),
        .o_winner_row    (o_winner_row),
        .o_winner_col    (o_winner_col),
        .o_best_distance (o_best_distance),
        .o_weight_out    (o_weight_out),
        .o_end_of_run    (o_end_of_run)
    );

endmodule
`default_nettype wire
